/* rtl/drbd_pkg.sv */
package drbd_pkg;

   localparam int FEAT_W       = 24;
   localparam int CC_W         = 8;
   localparam int SIZE_W       = 13;
   localparam int AREA_W       = 26;
   localparam int COORD_W      = 14;
   localparam int CLASS_W      = 7;
   localparam int MAG_W        = 25;
   localparam int NUM_W        = 26;
   localparam int PROD_W       = MAG_W + SIZE_W;
   localparam int BOX_FEATURES = 5;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 26;

   localparam int MAX_CLASSES_DEF = 128;
   localparam int FRAC_BITS_DEF   = 12;

   // row positions of the box features
   localparam int ROW_CX  = 0;
   localparam int ROW_CY  = 1;
   localparam int ROW_W   = 2;
   localparam int ROW_H   = 3;
   localparam int ROW_OBJ = 4;

   // saturation limits of the box outputs
   localparam int COORD_MAX     = 8191;
   localparam int COORD_MIN_MAG = 8192;
   localparam int SIZE_MAX      = 8191;

   localparam logic [CSR_IDX_W-1:0] CSR_CONF_LIMIT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLASS_COUNT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NET_WIDTH     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_NET_HEIGHT    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_AREA      = 3'd6;

   localparam logic [FEAT_W-1:0] CONF_LIMIT_RST    = 24'd2048;
   localparam logic [CC_W-1:0]   CLASS_COUNT_RST   = 8'd4;
   localparam logic [SIZE_W-1:0] SOURCE_WIDTH_RST  = 13'd640;
   localparam logic [SIZE_W-1:0] SOURCE_HEIGHT_RST = 13'd480;
   localparam logic [SIZE_W-1:0] NET_WIDTH_RST     = 13'd640;
   localparam logic [SIZE_W-1:0] NET_HEIGHT_RST    = 13'd640;
   localparam logic [AREA_W-1:0] MIN_AREA_RST      = 26'd50;

   typedef struct packed {
      logic [FEAT_W-1:0]  cx;
      logic [FEAT_W-1:0]  cy;
      logic [FEAT_W-1:0]  w;
      logic [FEAT_W-1:0]  h;
      logic [FEAT_W-1:0]  obj;
      logic [FEAT_W-1:0]  top_score;
      logic [CLASS_W-1:0] top_class;
   } row_type;

   typedef struct packed {
      logic [FEAT_W-1:0] conf_limit;
      logic [SIZE_W-1:0] source_width;
      logic [SIZE_W-1:0] source_height;
      logic [SIZE_W-1:0] net_width;
      logic [SIZE_W-1:0] net_height;
      logic [AREA_W-1:0] min_area;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_CONF,
      BK_TEST,
      BK_LOAD,
      BK_DIV,
      BK_SAVE,
      BK_AREA,
      BK_SEND
   } back_state_type;

endpackage

/* rtl/drbd_front.sv */
module drbd_front #(
   parameter int MAX_CLASSES = drbd_pkg::MAX_CLASSES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        accept,
   input  logic [drbd_pkg::FEAT_W-1:0] feature,
   input  logic                        tensor_start,
   input  logic [drbd_pkg::CC_W-1:0]   class_count,
   output logic                        push,
   output drbd_pkg::row_type           row
);
   import drbd_pkg::*;

   localparam int POS_W = $clog2(MAX_CLASSES + BOX_FEATURES);
   localparam int IDX_W = (POS_W > CLASS_W) ? POS_W : CLASS_W;
   localparam int CMP_W = (POS_W > CC_W) ? POS_W : CC_W;

   logic [POS_W-1:0]   pos_ff, pos_in, pos, last;
   logic [FEAT_W-1:0]  cx_ff, cx_in, cy_ff, cy_in, w_ff, w_in, h_ff, h_in, obj_ff, obj_in;
   logic [FEAT_W-1:0]  best_ff, best_in;
   logic [CLASS_W-1:0] class_ff, class_in;
   logic [CMP_W-1:0]   cc_wide, cc_eff;
   logic [IDX_W-1:0]   class_diff;
   logic               end_row;

   always_comb begin
      cc_wide = CMP_W'(class_count);
      if (class_count == '0) begin
         cc_eff = CMP_W'(1);
      end else if (cc_wide > CMP_W'(MAX_CLASSES)) begin
         cc_eff = CMP_W'(MAX_CLASSES);
      end else begin
         cc_eff = cc_wide;
      end
      last = POS_W'(cc_eff) + POS_W'(BOX_FEATURES - 1);
      pos  = tensor_start ? '0 : pos_ff;
      class_diff = IDX_W'(pos) - IDX_W'(BOX_FEATURES);

      cx_in    = cx_ff;
      cy_in    = cy_ff;
      w_in     = w_ff;
      h_in     = h_ff;
      obj_in   = obj_ff;
      best_in  = best_ff;
      class_in = class_ff;
      case (pos)
         POS_W'(ROW_CX): begin
            cx_in    = feature;
            best_in  = '0;
            class_in = '0;
         end
         POS_W'(ROW_CY):  cy_in  = feature;
         POS_W'(ROW_W):   w_in   = feature;
         POS_W'(ROW_H):   h_in   = feature;
         POS_W'(ROW_OBJ): obj_in = feature;
         default: begin
            if (feature > best_ff) begin
               best_in  = feature;
               class_in = class_diff[CLASS_W-1:0];
            end
         end
      endcase

      end_row = (pos >= last);
      pos_in  = end_row ? '0 : pos + POS_W'(1);
   end

   assign push = accept && end_row;

   // the last feature of a row is always a class score, so the box holds are settled
   assign row = '{cx: cx_ff, cy: cy_ff, w: w_ff, h: h_ff, obj: obj_ff,
                  top_score: best_in, top_class: class_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         w_ff     <= w_in;
         h_ff     <= h_in;
         obj_ff   <= obj_in;
         best_ff  <= best_in;
         class_ff <= class_in;
      end
   end

endmodule

/* rtl/drbd_queue.sv */
module drbd_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  drbd_pkg::row_type          push_row,
   input  logic                       pop,
   output drbd_pkg::row_type          pop_row,
   output drbd_pkg::queue_status_type status
);
   import drbd_pkg::*;

   row_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   assign pop_row      = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_row;
      end
   end

endmodule

/* rtl/drbd_back.sv */
module drbd_back #(
   parameter int FRAC_BITS = drbd_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  drbd_pkg::cfg_type                   cfg,
   input  drbd_pkg::queue_status_type          q_status,
   input  drbd_pkg::row_type                   q_row,
   output logic                                pop,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [drbd_pkg::COORD_W-1:0] rsp_box_left,
   output logic signed [drbd_pkg::COORD_W-1:0] rsp_box_top,
   output logic [drbd_pkg::SIZE_W-1:0]         rsp_box_width,
   output logic [drbd_pkg::SIZE_W-1:0]         rsp_box_height,
   output logic [drbd_pkg::FEAT_W-1:0]         rsp_score,
   output logic [drbd_pkg::CLASS_W-1:0]        rsp_class_index
);
   import drbd_pkg::*;

   localparam int DIV_W = PROD_W - FRAC_BITS - 1;
   localparam int CNT_W = $clog2(DIV_W);
   localparam int CP_W  = 2 * FEAT_W;

   back_state_type state_ff, state_in;

   row_type            row_ff;
   logic [CP_W-1:0]    prod_ff, conf_shift;
   logic [FEAT_W-1:0]  conf, score_ff;
   logic               pass;
   logic [1:0]         sel_ff;
   logic               neg_ff;
   logic [DIV_W-1:0]   quo_ff, quo_in;
   logic [SIZE_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]   cnt_ff;
   logic [COORD_W-1:0] left_ff, top_ff, coord;
   logic [SIZE_W-1:0]  bw_ff, bh_ff, size_sat;
   logic [AREA_W-1:0]  area;

   logic [NUM_W-1:0]   num, mag_full;
   logic [MAG_W-1:0]   mag;
   logic               num_neg;
   logic [SIZE_W-1:0]  src, net, net_eff;
   logic [PROD_W-1:0]  mag_prod;
   logic [SIZE_W:0]    trial;
   logic               ge;
   logic               out_free, load_out;
   logic               rsp_valid_ff;

   // confidence and thresholds
   always_comb begin
      conf_shift = prod_ff >> FRAC_BITS;
      conf = (|conf_shift[CP_W-1:FEAT_W]) ? '1 : conf_shift[FEAT_W-1:0];
      pass = (row_ff.obj >= cfg.conf_limit) && (conf >= cfg.conf_limit);
   end

   // numerator in half-pixel units, then scale by source size
   always_comb begin
      case (sel_ff)
         2'd0:    num = {1'b0, row_ff.cx, 1'b0} - {2'b00, row_ff.w};
         2'd1:    num = {1'b0, row_ff.cy, 1'b0} - {2'b00, row_ff.h};
         2'd2:    num = {1'b0, row_ff.w, 1'b0};
         default: num = {1'b0, row_ff.h, 1'b0};
      endcase
      num_neg  = num[NUM_W-1];
      mag_full = num_neg ? (~num + NUM_W'(1)) : num;
      mag      = mag_full[MAG_W-1:0];
      src      = sel_ff[0] ? cfg.source_height : cfg.source_width;
      net      = sel_ff[0] ? cfg.net_height : cfg.net_width;
      net_eff  = (net == '0) ? SIZE_W'(1) : net;
      mag_prod = PROD_W'(mag) * PROD_W'(src);
   end

   // restoring divide, one quotient bit per cycle; quotient shifts in behind the dividend
   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_W-1]};
      ge     = (trial >= {1'b0, net_eff});
      rem_in = ge ? SIZE_W'(trial - {1'b0, net_eff}) : trial[SIZE_W-1:0];
      quo_in = {quo_ff[DIV_W-2:0], ge};
   end

   always_comb begin
      if (neg_ff) begin
         coord = (quo_ff > DIV_W'(COORD_MIN_MAG)) ? COORD_W'(COORD_MIN_MAG)
                                                  : COORD_W'(~quo_ff[COORD_W-1:0] + 1'b1);
      end else begin
         coord = (quo_ff > DIV_W'(COORD_MAX)) ? COORD_W'(COORD_MAX) : quo_ff[COORD_W-1:0];
      end
      size_sat = (quo_ff > DIV_W'(SIZE_MAX)) ? SIZE_W'(SIZE_MAX) : quo_ff[SIZE_W-1:0];
      area     = AREA_W'(bw_ff) * AREA_W'(bh_ff);
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (!q_status.empty) state_in = BK_CONF;
         BK_CONF: state_in = BK_TEST;
         BK_TEST: state_in = pass ? BK_LOAD : BK_IDLE;
         BK_LOAD: state_in = BK_DIV;
         BK_DIV:  if (cnt_ff == '0) state_in = BK_SAVE;
         BK_SAVE: state_in = (sel_ff == 2'd3) ? BK_AREA : BK_LOAD;
         BK_AREA: state_in = (area > cfg.min_area) ? BK_SEND : BK_IDLE;
         BK_SEND: if (out_free) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop      = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         BK_IDLE: pop = !q_status.empty;
         BK_SEND: load_out = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            row_ff <= q_row;
            sel_ff <= 2'd0;
         end
         BK_CONF: prod_ff <= CP_W'(row_ff.obj) * CP_W'(row_ff.top_score);
         BK_TEST: score_ff <= conf;
         BK_LOAD: begin
            neg_ff <= num_neg;
            quo_ff <= mag_prod[PROD_W-1:FRAC_BITS+1];
            rem_ff <= '0;
            cnt_ff <= CNT_W'(DIV_W - 1);
         end
         BK_DIV: begin
            quo_ff <= quo_in;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         BK_SAVE: begin
            case (sel_ff)
               2'd0:    left_ff <= coord;
               2'd1:    top_ff  <= coord;
               2'd2:    bw_ff   <= size_sat;
               default: bh_ff   <= size_sat;
            endcase
            sel_ff <= sel_ff + 2'd1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_box_left    <= $signed(left_ff);
         rsp_box_top     <= $signed(top_ff);
         rsp_box_width   <= bw_ff;
         rsp_box_height  <= bh_ff;
         rsp_score       <= score_ff;
         rsp_class_index <= row_ff.top_class;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/detection_row_box_decode_top.sv */
// Decodes detector output rows into boxes. Features stream in one beat per cycle on req_;
// each row is cx, cy, w, h, objectness and class_count class scores, and tensor_start
// restarts the row. The front tracks the argmax at one beat per cycle and hands each
// finished row to a two-row queue. The back drops a row that fails the objectness or
// confidence test; otherwise one shared bit-serial divider does the four box scalings
// in turn, and a kept box then sits in the rsp_ output register. Input stalls only when
// both queue entries are taken. Configuration writes are always accepted.
module detection_row_box_decode_top #(
   parameter int MAX_CLASSES = drbd_pkg::MAX_CLASSES_DEF,
   parameter int FRAC_BITS   = drbd_pkg::FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [drbd_pkg::FEAT_W-1:0]         req_feature,
   input  logic                                req_tensor_start,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [drbd_pkg::COORD_W-1:0] rsp_box_left,
   output logic signed [drbd_pkg::COORD_W-1:0] rsp_box_top,
   output logic [drbd_pkg::SIZE_W-1:0]         rsp_box_width,
   output logic [drbd_pkg::SIZE_W-1:0]         rsp_box_height,
   output logic [drbd_pkg::FEAT_W-1:0]         rsp_score,
   output logic [drbd_pkg::CLASS_W-1:0]        rsp_class_index,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [drbd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [drbd_pkg::CSR_DATA_W-1:0]     csr_data
);
   import drbd_pkg::*;

   cfg_type          cfg_ff;
   logic [CC_W-1:0]  class_count_ff;
   queue_status_type q_status;
   row_type          push_row, pop_row;
   logic             accept, push, pop;

   assign csr_ready = 1'b1;
   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.conf_limit    <= CONF_LIMIT_RST;
         class_count_ff       <= CLASS_COUNT_RST;
         cfg_ff.source_width  <= SOURCE_WIDTH_RST;
         cfg_ff.source_height <= SOURCE_HEIGHT_RST;
         cfg_ff.net_width     <= NET_WIDTH_RST;
         cfg_ff.net_height    <= NET_HEIGHT_RST;
         cfg_ff.min_area      <= MIN_AREA_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CONF_LIMIT:    cfg_ff.conf_limit    <= csr_data[FEAT_W-1:0];
            CSR_CLASS_COUNT:   class_count_ff       <= csr_data[CC_W-1:0];
            CSR_SOURCE_WIDTH:  cfg_ff.source_width  <= csr_data[SIZE_W-1:0];
            CSR_SOURCE_HEIGHT: cfg_ff.source_height <= csr_data[SIZE_W-1:0];
            CSR_NET_WIDTH:     cfg_ff.net_width     <= csr_data[SIZE_W-1:0];
            CSR_NET_HEIGHT:    cfg_ff.net_height    <= csr_data[SIZE_W-1:0];
            CSR_MIN_AREA:      cfg_ff.min_area      <= csr_data[AREA_W-1:0];
            default: ;
         endcase
      end
   end

   drbd_front #(
      .MAX_CLASSES (MAX_CLASSES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .feature      (req_feature),
      .tensor_start (req_tensor_start),
      .class_count  (class_count_ff),
      .push         (push),
      .row          (push_row)
   );

   drbd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_row (push_row),
      .pop      (pop),
      .pop_row  (pop_row),
      .status   (q_status)
   );

   drbd_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_status        (q_status),
      .q_row           (pop_row),
      .pop             (pop),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_box_left    (rsp_box_left),
      .rsp_box_top     (rsp_box_top),
      .rsp_box_width   (rsp_box_width),
      .rsp_box_height  (rsp_box_height),
      .rsp_score       (rsp_score),
      .rsp_class_index (rsp_class_index)
   );

endmodule

/* rtl/drbd_checker.sv */
module drbd_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [drbd_pkg::COORD_W-1:0] rsp_box_left,
   input logic signed [drbd_pkg::COORD_W-1:0] rsp_box_top,
   input logic [drbd_pkg::SIZE_W-1:0]         rsp_box_width,
   input logic [drbd_pkg::SIZE_W-1:0]         rsp_box_height,
   input logic [drbd_pkg::FEAT_W-1:0]         rsp_score,
   input logic [drbd_pkg::CLASS_W-1:0]        rsp_class_index
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_box_left) && $stable(rsp_box_top)
         && $stable(rsp_box_width) && $stable(rsp_box_height) && $stable(rsp_score)
         && $stable(rsp_class_index))
      else $error("result beat changed while stalled");

   // area test passed, so neither side can be zero
   a_rsp_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_box_width != '0 && rsp_box_height != '0)
      else $error("result with zero-sized box");

   a_rst_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind detection_row_box_decode_top drbd_checker u_drbd_checker (.*);
